### design/kwm_pkg.sv
package kwm_pkg;

  typedef enum logic [1:0] {
    KIND_VALUE = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } kwm_kind_t;

  // control from the sequencer to the shared min unit
  typedef struct packed {
    logic clear;
    logic take;
  } kwm_cmp_ctl_t;

  localparam int unsigned WAY_W   = 3;
  localparam int unsigned ELEM_W  = 64;
  localparam int unsigned COUNT_W = 4;

endpackage

### design/kwm_in_if.sv
interface kwm_in_if import kwm_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [WAY_W-1:0]         source_way;
  logic signed [ELEM_W-1:0] element;
  logic                     stream_ended;

  modport source (output valid, source_way, element, stream_ended, input ready);
  modport sink (input valid, source_way, element, stream_ended, output ready);
endinterface

### design/kwm_out_if.sv
interface kwm_out_if import kwm_pkg::*; ();
  logic                     valid;
  logic                     ready;
  kwm_kind_t                kind;
  logic signed [ELEM_W-1:0] merged_value;
  logic [WAY_W-1:0]         refill_way;

  modport source (output valid, kind, merged_value, refill_way, input ready);
  modport sink (input valid, kind, merged_value, refill_way, output ready);
endinterface

### design/kwm_cfg_if.sv
interface kwm_cfg_if import kwm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] ways_in_use;

  modport source (output valid, ways_in_use, input ready);
  modport sink (input valid, ways_in_use, output ready);
endinterface

### design/k_way_sorted_merge_core.sv
// k-way sorted merge core
//
// channels: req carries one item per transfer (source_way, element,
// stream_ended); rsp carries at most one result per item (kind,
// merged_value, refill_way); cfg writes ways_in_use, taken at once,
// and is meant to be written only while no item is in progress.
// an item loads a way head or marks the way ended; once every way in use
// holds a head or has ended, the smallest head goes out on rsp and that
// way must send its next value. all ways ended gives a finished result
// and clears the merge state; a bad item gives an error result.
// timing: req is taken one item at a time. the heads sit in a ram and
// one shared comparator walks them one way per cycle; a single way
// skips the scan.
// rsp is held in an output register; a new item is taken while a result
// waits, but the next result waits until rsp is free.
// reset (rst, synchronous) clears all marks, sets ways_in_use to 8 and
// empties the output register; req and cfg are not ready during reset.
module k_way_sorted_merge_core import kwm_pkg::*; #(
  parameter int unsigned WAYS = 8
) (
  input  logic      clk,
  input  logic      rst,
  kwm_in_if.sink    req,
  kwm_out_if.source rsp,
  kwm_cfg_if.sink   cfg
);

  localparam int unsigned CAP  = (WAYS < 8) ? WAYS : 8;
  localparam int unsigned AW   = (WAYS > 1) ? $clog2(WAYS) : 1;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_EVAL = 5'b00010,
    ST_SCAN = 5'b00100,
    ST_LAST = 5'b01000,
    ST_EMIT = 5'b10000
  } state_t;

  state_t state, state_next;

  logic [COUNT_W-1:0] ways_in_use;
  logic [COUNT_W-1:0] n_act;
  logic [WAYS-1:0]    head_valid;
  logic [WAYS-1:0]    way_ended;
  logic [WAYS-1:0]    in_use;
  logic [WAYS-1:0]    req_sel;
  logic [WAYS-1:0]    prev_sel;
  logic [WAYS-1:0]    best_sel;
  logic               all_rdy;
  logic               all_end;
  logic               req_err;
  logic               accept;

  kwm_kind_t   res_kind;
  logic [WAY_W-1:0] scan_idx;
  logic [WAY_W-1:0] prev_idx;
  logic             prev_valid;

  logic [ELEM_W-1:0]        rd_data;
  kwm_cmp_ctl_t             cmp_ctl;
  logic                     found;
  logic signed [ELEM_W-1:0] best_value;
  logic [WAY_W-1:0]         best_way;
  logic                     rsp_free;
  logic                     rsp_load;

  function automatic logic [WAYS-1:0] way_dec(input logic [WAY_W-1:0] w);
    logic [WAYS-1:0] d;
    for (int i = 0; i < WAYS; i++) begin
      d[i] = (32'(w) == i);
    end
    return d;
  endfunction

  // zero acts as one, above the cap acts as the cap
  always_comb begin
    if (ways_in_use == '0) begin
      n_act = COUNT_W'(1);
    end else if (32'(ways_in_use) > CAP) begin
      n_act = COUNT_W'(CAP);
    end else begin
      n_act = ways_in_use;
    end
  end

  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      in_use[i] = (32'(n_act) > i);
    end
  end

  assign req_sel  = way_dec(req.source_way);
  assign prev_sel = way_dec(prev_idx);
  assign best_sel = way_dec(best_way);
  assign all_rdy  = &(head_valid | way_ended | ~in_use);
  assign all_end  = &(way_ended | ~in_use);
  assign req_err  = ({1'b0, req.source_way} >= n_act) ||
                    (|((head_valid | way_ended) & req_sel));

  assign req.ready = (state == ST_IDLE) && !rst;
  assign accept    = req.valid && req.ready;
  assign cfg.ready = !rst;
  assign rsp_free  = !rsp.valid || rsp.ready;
  assign rsp_load  = (state == ST_EMIT) && rsp_free &&
                     ((res_kind != KIND_VALUE) || found);

  always_ff @(posedge clk) begin
    if (rst) begin
      ways_in_use <= COUNT_W'(8);
    end else if (cfg.valid) begin
      ways_in_use <= cfg.ways_in_use;
    end
  end

  kwm_ram #(
    .WIDTH (ELEM_W),
    .DEPTH (WAYS)
  ) u_heads (
    .clk   (clk),
    .we    (accept && !req_err && !req.stream_ended),
    .waddr (AW'(req.source_way)),
    .wdata (req.element),
    .raddr (AW'(scan_idx)),
    .rdata (rd_data)
  );

  always_comb begin
    cmp_ctl.clear = (state == ST_EVAL);
    cmp_ctl.take  = ((state == ST_SCAN) || (state == ST_LAST)) && prev_valid &&
                    (|(head_valid & prev_sel));
  end

  kwm_min_unit u_min (
    .clk          (clk),
    .rst          (rst),
    .ctl          (cmp_ctl),
    .sample_value (signed'(rd_data)),
    .sample_way   (prev_idx),
    .found        (found),
    .best_value   (best_value),
    .best_way     (best_way)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = req_err ? ST_EMIT : ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (!all_rdy) begin
          state_next = ST_IDLE;
        end else if (all_end) begin
          state_next = ST_EMIT;
        end else if (n_act == COUNT_W'(1)) begin
          state_next = ST_LAST;
        end else begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if ({1'b0, scan_idx} == n_act - COUNT_W'(1)) begin
          state_next = ST_LAST;
        end
      end
      ST_LAST: state_next = ST_EMIT;
      ST_EMIT: begin
        if (rsp_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      head_valid <= '0;
      way_ended  <= '0;
      prev_valid <= 1'b0;
      scan_idx   <= '0;
      prev_idx   <= '0;
      res_kind   <= KIND_VALUE;
      rsp.valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (rsp_load) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (req_err) begin
              res_kind <= KIND_ERROR;
            end else if (req.stream_ended) begin
              way_ended <= way_ended | req_sel;
            end else begin
              head_valid <= head_valid | req_sel;
            end
          end
        end
        ST_EVAL: begin
          prev_valid <= 1'b0;
          scan_idx   <= '0;
          prev_idx   <= '0;
          if (all_rdy && all_end) begin
            head_valid <= '0;
            way_ended  <= '0;
            res_kind   <= KIND_DONE;
          end else begin
            res_kind <= KIND_VALUE;
            // single way: read of way 0 is issued here
            if (n_act == COUNT_W'(1)) begin
              prev_valid <= 1'b1;
            end
          end
        end
        ST_SCAN: begin
          prev_valid <= 1'b1;
          prev_idx   <= scan_idx;
          scan_idx   <= scan_idx + WAY_W'(1);
        end
        ST_LAST: begin
          prev_valid <= 1'b0;
          // park the read address on way 0 for the next evaluation
          scan_idx   <= '0;
        end
        ST_EMIT: begin
          if (rsp_load && res_kind == KIND_VALUE) begin
            head_valid <= head_valid & ~best_sel;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && rsp_free) begin
      rsp.kind <= res_kind;
      if (res_kind == KIND_VALUE) begin
        rsp.merged_value <= best_value;
        rsp.refill_way   <= best_way;
      end else begin
        rsp.merged_value <= '0;
        rsp.refill_way   <= '0;
      end
    end
  end

endmodule

### design/kwm_ram.sv
module kwm_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/kwm_min_unit.sv
module kwm_min_unit import kwm_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  kwm_cmp_ctl_t             ctl,
  input  logic signed [ELEM_W-1:0] sample_value,
  input  logic [WAY_W-1:0]         sample_way,
  output logic                     found,
  output logic signed [ELEM_W-1:0] best_value,
  output logic [WAY_W-1:0]         best_way
);

  logic better;

  // strict less keeps the earlier (lower) way on ties
  assign better = !found || (sample_value < best_value);

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (ctl.clear) begin
      found <= 1'b0;
    end else if (ctl.take && better) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!ctl.clear && ctl.take && better) begin
      best_value <= sample_value;
      best_way   <= sample_way;
    end
  end

endmodule
